// ===== src/hsa_pkg.sv =====
// hsa_pkg: shared types and fixed-point constants for the hsl saturation adjust block
// no dependencies; imported by hsa_front, hsa_gain, hsa_mix and hsl_saturation_adjust

package hsa_pkg;

    // q16 fixed point one
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    // saturation divider: (d << 16) / den, den up to 255, quotient up to 65536
    localparam int unsigned S_DW = 8;
    localparam int unsigned S_QW = 17;

    // gain divider: 2^32 / base, base in 257..65536, quotient below 2^24
    localparam int unsigned A_DW = 17;
    localparam int unsigned A_QW = 24;
    // 2^32 split as top part (2^32 >> A_QW) and zero low bits
    localparam logic [A_DW-1:0] A_REM_INIT = 17'd256;
    localparam logic [A_QW-1:0] A_LOW_INIT = 24'd0;

    // setting limits in percent
    localparam logic signed [7:0] SAT_MAX = 8'sd100;
    localparam logic signed [7:0] SAT_MIN = -8'sd100;

    // |p| * 65536 / 100 computed as (|p| * INC_RECIP) >> INC_SHIFT, exact for |p| <= 100
    localparam logic [23:0] INC_RECIP = 24'd10737419;
    localparam int unsigned INC_SHIFT = 14;

    // register stages from the accept edge to the edge that takes the result: front, both dividers, gain, mix
    localparam int unsigned LATENCY = 45;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [8:0] sum;   // max + min
        logic       grey;  // max == min
    } t_pix;

    typedef struct packed {
        t_pix pix;
        logic neg;         // desaturate path
    } t_pix_neg;

endpackage

// ===== src/hsa_front.sv =====
// hsa_front: channel max/min, lightness sum and saturation divider operands
// depends on hsa_pkg

module hsa_front import hsa_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_red,
    input  logic [7:0]      i_green,
    input  logic [7:0]      i_blue,
    output logic            o_valid,
    output t_pix            o_pix,
    output logic [S_DW-1:0] o_den,
    output logic [S_DW-1:0] o_rem,
    output logic [S_QW-1:0] o_low
);

    logic [7:0] mx, mn, d;
    logic [8:0] sum, den_hi;
    logic [7:0] den;

    logic       r_vld;
    t_pix       r_pix;
    logic [7:0] r_d;
    logic [7:0] r_den;

    always_comb begin
        mx = i_red;
        mn = i_red;
        if (i_green > mx) mx = i_green;
        if (i_blue  > mx) mx = i_blue;
        if (i_green < mn) mn = i_green;
        if (i_blue  < mn) mn = i_blue;
        d      = mx - mn;
        sum    = {1'b0, mx} + {1'b0, mn};
        den_hi = 9'd510 - sum;
        den    = (sum < 9'd255) ? sum[7:0] : den_hi[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix.red   <= i_red;
        r_pix.green <= i_green;
        r_pix.blue  <= i_blue;
        r_pix.sum   <= sum;
        r_pix.grey  <= (d == 8'd0);
        r_d         <= d;
        r_den       <= den;
    end

    // dividend d * 2^16: top part d >> 1 is below den, the rest is shifted in
    assign o_valid = r_vld;
    assign o_pix   = r_pix;
    assign o_den   = r_den;
    assign o_rem   = {1'b0, r_d[7:1]};
    assign o_low   = {r_d[0], 16'd0};

endmodule

// ===== src/hsa_divider.sv =====
// hsa_divider: pipelined restoring divider, one quotient bit per register stage
// standalone; dividend given as top part (below divisor) and QW low bits

module hsa_divider #(
    parameter int unsigned DW = 8,
    parameter int unsigned QW = 17,
    parameter int unsigned SW = 34
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [DW-1:0] i_divisor,
    input  logic [DW-1:0] i_rem,
    input  logic [QW-1:0] i_low,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quot,
    output logic [SW-1:0] o_side
);

    logic          r_vld  [QW];
    logic [DW-1:0] r_rem  [QW];
    logic [QW-1:0] r_dq   [QW];
    logic [DW-1:0] r_div  [QW];
    logic [SW-1:0] r_side [QW];

    for (genvar g = 0; g < QW; g++) begin : g_stage
        logic          p_vld;
        logic [DW-1:0] p_rem, p_div;
        logic [QW-1:0] p_dq;
        logic [SW-1:0] p_side;
        logic [DW:0]   t, diff;
        logic          ge;
        logic [DW-1:0] n_rem;
        logic [QW-1:0] n_dq;

        if (g == 0) begin : g_first
            assign p_vld  = i_valid;
            assign p_rem  = i_rem;
            assign p_div  = i_divisor;
            assign p_dq   = i_low;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = r_vld[g-1];
            assign p_rem  = r_rem[g-1];
            assign p_div  = r_div[g-1];
            assign p_dq   = r_dq[g-1];
            assign p_side = r_side[g-1];
        end

        // shift in the next dividend bit, subtract when it fits
        always_comb begin
            t     = {p_rem, p_dq[QW-1]};
            diff  = t - {1'b0, p_div};
            ge    = (t >= {1'b0, p_div});
            n_rem = ge ? diff[DW-1:0] : t[DW-1:0];
            n_dq  = {p_dq[QW-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else begin
                r_vld[g] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[g]  <= n_rem;
            r_dq[g]   <= n_dq;
            r_div[g]  <= p_div;
            r_side[g] <= p_side;
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quot  = r_dq[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

// ===== src/hsa_gain.sv =====
// hsa_gain: setting clamp and q16 increment, divisor selection for the gain divider
// depends on hsa_pkg

module hsa_gain import hsa_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [7:0]      i_sat,
    input  logic            i_valid,
    input  t_pix            i_pix,
    input  logic [S_QW-1:0] i_sq,
    output logic            o_valid,
    output t_pix_neg        o_side,
    output logic [A_DW-1:0] o_base,
    output logic [16:0]     o_inc_mag
);

    logic signed [7:0] p;
    logic [6:0]        mag;
    logic [30:0]       inc_prod;
    logic [17:0]       inc_plus_s;
    logic [A_DW-1:0]   n_base;

    logic              r_neg;
    logic [16:0]       r_inc_mag;
    logic              r_vld;
    t_pix_neg          r_side;
    logic [A_DW-1:0]   r_base;

    always_comb begin
        p = $signed(i_sat);
        if (p < SAT_MIN) p = SAT_MIN;
        if (p > SAT_MAX) p = SAT_MAX;
        mag      = p[7] ? 7'(-p) : p[6:0];
        inc_prod = 31'({24'd0, mag} * {7'd0, INC_RECIP});
    end

    // user keeps setting fixed while items flow (unenforced); settles before use
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neg     <= 1'b0;
            r_inc_mag <= 17'd0;
        end else begin
            r_neg     <= p[7];
            r_inc_mag <= inc_prod[INC_SHIFT +: 17];
        end
    end

    // grey and desaturate items never use the quotient: feed a harmless divisor
    always_comb begin
        inc_plus_s = {1'b0, r_inc_mag} + {1'b0, i_sq};
        if (r_neg || i_pix.grey) begin
            n_base = ONE_Q16;
        end else if (inc_plus_s >= {1'b0, ONE_Q16}) begin
            n_base = i_sq;
        end else begin
            n_base = ONE_Q16 - r_inc_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side.pix <= i_pix;
        r_side.neg <= r_neg;
        r_base     <= n_base;
    end

    assign o_valid   = r_vld;
    assign o_side    = r_side;
    assign o_base    = r_base;
    assign o_inc_mag = r_inc_mag;

endmodule

// ===== src/hsa_mix.sv =====
// hsa_mix: per-channel multiply, q17 accumulate, truncate and clamp to byte
// depends on hsa_pkg

module hsa_mix import hsa_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  t_pix_neg        i_side,
    input  logic [A_QW-1:0] i_quot,
    input  logic [16:0]     i_inc_mag,
    output logic            o_valid,
    output logic [7:0]      o_red,
    output logic [7:0]      o_green,
    output logic [7:0]      o_blue
);

    logic [7:0]         ch [3];
    logic [A_QW-1:0]    alpha, k;
    logic [16:0]        f;
    logic signed [9:0]  diff [3];
    logic signed [34:0] n_prod [3];
    logic [24:0]        n_basev [3];

    logic               r_vld1;
    logic signed [34:0] r_prod [3];
    logic [24:0]        r_basev [3];
    logic [7:0]         r_ch [3];
    logic               r_grey;

    logic signed [35:0] acc [3];
    logic [7:0]         n_out [3];

    logic               r_vld2;
    logic [7:0]         r_out [3];

    always_comb begin
        ch[0] = i_side.pix.red;
        ch[1] = i_side.pix.green;
        ch[2] = i_side.pix.blue;
        alpha = i_quot - A_QW'(ONE_Q16);
        f     = ONE_Q16 - i_inc_mag;
        k     = i_side.neg ? {{(A_QW-17){1'b0}}, f} : alpha;
        for (int i = 0; i < 3; i++) begin
            diff[i]    = $signed({1'b0, ch[i], 1'b0}) - $signed({1'b0, i_side.pix.sum});
            n_prod[i]  = diff[i] * $signed({1'b0, k});
            n_basev[i] = i_side.neg ? {i_side.pix.sum, 16'd0} : {ch[i], 17'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_prod[i]  <= n_prod[i];
            r_basev[i] <= n_basev[i];
            r_ch[i]    <= ch[i];
        end
        r_grey <= i_side.pix.grey;
    end

    // grey pixels pass through; otherwise floor of q17, negative to zero, overflow to full scale
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc[i] = $signed({11'd0, r_basev[i]}) + {r_prod[i][34], r_prod[i]};
            if (r_grey) begin
                n_out[i] = r_ch[i];
            end else if (acc[i][35]) begin
                n_out[i] = 8'd0;
            end else if (|acc[i][34:25]) begin
                n_out[i] = 8'd255;
            end else begin
                n_out[i] = acc[i][24:17];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_out[i] <= n_out[i];
        end
    end

    assign o_valid = r_vld2;
    assign o_red   = r_out[0];
    assign o_green = r_out[1];
    assign o_blue  = r_out[2];

endmodule

// ===== src/hsl_saturation_adjust.sv =====
// hsl_saturation_adjust: top level, apb setting register and pixel pipeline
// depends on hsa_pkg, hsa_front, hsa_divider, hsa_gain, hsa_mix

// hsl saturation adjust, one rgb pixel per item
//
// pixel in: drive i_red_in, i_green_in, i_blue_in with start high; the item
//   is taken at that clock edge. busy is always low, so an item can be taken
//   at every edge and many items are in flight at once.
// pixel out: o_valid is high for exactly one cycle with o_red_out,
//   o_green_out, o_blue_out. results come out in input order. there is no
//   back pressure: the receiver must take each result in its cycle.
// pipeline: the two pipelined dividers hold most of the stages: 17 stages
//   for the hsl saturation and 24 stages for the gain 2^32/base, one quotient
//   bit each; front, gain select and the two mix stages add the rest.
// throughput: one item per cycle.
// setting: apb register at address 0, signed percent; values beyond +-100
//   act as +-100. write it only while no item is in flight.
// reset: synchronous, active low. clears the setting to 0 and drops every
//   item in flight; no results appear until new items enter.

module hsl_saturation_adjust import hsa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // pixel channel
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    // result channel
    output logic        o_valid,
    output logic [7:0]  o_red_out,
    output logic [7:0]  o_green_out,
    output logic [7:0]  o_blue_out,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [1:0] ADDR_SAT = 2'd0;

    // setting register
    logic [7:0] r_sat;
    logic       cfg_wr;

    // front to saturation divider
    logic            f_vld;
    t_pix            f_pix;
    logic [S_DW-1:0] f_den, f_rem;
    logic [S_QW-1:0] f_low;

    // saturation divider out
    logic            s_vld;
    logic [S_QW-1:0] s_quot;
    logic [$bits(t_pix)-1:0] s_side_bits;
    t_pix            s_pix;

    // gain stage out
    logic            g_vld;
    t_pix_neg        g_side;
    logic [A_DW-1:0] g_base;
    logic [16:0]     inc_mag;

    // gain divider out
    logic            a_vld;
    logic [A_QW-1:0] a_quot;
    logic [$bits(t_pix_neg)-1:0] a_side_bits;
    t_pix_neg        a_side;

    logic            accept;

    assign accept = start && !busy;
    assign busy   = 1'b0;
    assign pready = 1'b1;

    // apb: no wait states
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_SAT);
    assign prdata = (paddr == ADDR_SAT) ? {24'd0, r_sat} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat <= 8'd0;
        end else if (cfg_wr) begin
            r_sat <= pwdata[7:0];
        end
    end

    // stage 1: max, min, sum and divider operands
    hsa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_red   (i_red_in),
        .i_green (i_green_in),
        .i_blue  (i_blue_in),
        .o_valid (f_vld),
        .o_pix   (f_pix),
        .o_den   (f_den),
        .o_rem   (f_rem),
        .o_low   (f_low)
    );

    // hsl saturation s = (d << 16) / den
    hsa_divider #(
        .DW (S_DW),
        .QW (S_QW),
        .SW ($bits(t_pix))
    ) u_sat_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (f_vld),
        .i_divisor (f_den),
        .i_rem     (f_rem),
        .i_low     (f_low),
        .i_side    (f_pix),
        .o_valid   (s_vld),
        .o_quot    (s_quot),
        .o_side    (s_side_bits)
    );

    assign s_pix = t_pix'(s_side_bits);

    // pick the gain divisor: s when the boost would reach full saturation
    hsa_gain u_gain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_sat     (r_sat),
        .i_valid   (s_vld),
        .i_pix     (s_pix),
        .i_sq      (s_quot),
        .o_valid   (g_vld),
        .o_side    (g_side),
        .o_base    (g_base),
        .o_inc_mag (inc_mag)
    );

    // gain quotient 2^32 / base, alpha = quotient - 1.0
    hsa_divider #(
        .DW (A_DW),
        .QW (A_QW),
        .SW ($bits(t_pix_neg))
    ) u_gain_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (g_vld),
        .i_divisor (g_base),
        .i_rem     (A_REM_INIT),
        .i_low     (A_LOW_INIT),
        .i_side    (g_side),
        .o_valid   (a_vld),
        .o_quot    (a_quot),
        .o_side    (a_side_bits)
    );

    assign a_side = t_pix_neg'(a_side_bits);

    // push away from or pull toward lightness, then clamp
    hsa_mix u_mix (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (a_vld),
        .i_side    (a_side),
        .i_quot    (a_quot),
        .i_inc_mag (inc_mag),
        .o_valid   (o_valid),
        .o_red     (o_red_out),
        .o_green   (o_green_out),
        .o_blue    (o_blue_out)
    );

`ifndef ASSERT_OFF
    // every item leaves after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_valid)
        else $error("result missing after fixed latency");

    // grey pixels pass through untouched (checked on red and blue)
    a_grey_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_red_in == i_green_in) && (i_green_in == i_blue_in)
        |-> ##LATENCY (o_red_out == $past(i_red_in, LATENCY))
                   && (o_blue_out == $past(i_blue_in, LATENCY)))
        else $error("grey pixel altered");

    // the adjustment keeps the red >= green and green >= blue channel order
    a_order_rg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_red_in >= i_green_in) |-> ##LATENCY (o_red_out >= o_green_out))
        else $error("red/green order flipped");

    a_order_gb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_green_in >= i_blue_in) |-> ##LATENCY (o_green_out >= o_blue_out))
        else $error("green/blue order flipped");
`endif

endmodule
